>>> hdl/sitda_pkg.sv
// shared types and constants for the signed integer to decimal ascii block
// no dependencies
package sitda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 7;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_HOLD
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SIGN,
        EMIT_SKIP,
        EMIT_DIGIT
    } emit_state_t;

    // converted number handed from converter to emitter
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } bcd_beat_t;

endpackage

>>> hdl/sitda_conv.sv
// binary to bcd converter, one magnitude bit per cycle (shift and add 3)
// depends on sitda_pkg
module sitda_conv (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
    output sitda_pkg::bcd_beat_t              out_beat,
    input  logic                              out_take
);
    import sitda_pkg::*;

    conv_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic                 neg_reg, neg_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 last_bit;

    assign last_bit = (cnt_reg == BIT_CNT_W'(VALUE_W - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CONV_IDLE:  if (in_valid) state_next = CONV_SHIFT;
            CONV_SHIFT: if (last_bit) state_next = CONV_HOLD;
            CONV_HOLD:  if (out_take) state_next = CONV_IDLE;
            default:    state_next = CONV_IDLE;
        endcase
    end

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            CONV_IDLE: begin
                neg_next = in_value[VALUE_W-1];
                mag_next = in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                               : VALUE_W'(in_value);
                bcd_next = '0;
                cnt_next = '0;
            end
            CONV_SHIFT: begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign in_ready       = (state_reg == CONV_IDLE);
    assign out_beat.valid = (state_reg == CONV_HOLD);
    assign out_beat.neg   = neg_reg;
    assign out_beat.bcd   = bcd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CONV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

endmodule

>>> hdl/sitda_emit.sv
// character emitter: sign, leading zero skip, one digit per beat
// depends on sitda_pkg
module sitda_emit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sitda_pkg::bcd_beat_t           in_beat,
    output logic                           in_take,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sitda_pkg::CHAR_W-1:0]   m_ascii_char,
    output logic                           m_is_last
);
    import sitda_pkg::*;

    emit_state_t          state_reg, state_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [DIG_CNT_W-1:0] rem_reg, rem_next;
    logic                 valid_reg, valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;
    logic                 slot_free;
    logic [3:0]           top_digit;
    logic                 one_left;

    assign slot_free = !valid_reg || m_ready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign one_left  = (rem_reg == DIG_CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EMIT_IDLE: begin
                if (in_beat.valid) state_next = in_beat.neg ? EMIT_SIGN : EMIT_SKIP;
            end
            EMIT_SIGN:  if (slot_free) state_next = EMIT_SKIP;
            EMIT_SKIP:  if (top_digit != 4'd0 || one_left) state_next = EMIT_DIGIT;
            EMIT_DIGIT: if (slot_free && one_left) state_next = EMIT_IDLE;
            default:    state_next = EMIT_IDLE;
        endcase
    end

    always_comb begin
        bcd_next   = bcd_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg && !m_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        case (state_reg)
            EMIT_IDLE: begin
                bcd_next = in_beat.bcd;
                rem_next = DIG_CNT_W'(NUM_DIGITS);
            end
            EMIT_SIGN: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                end
            end
            EMIT_SKIP: begin
                if (top_digit == 4'd0 && !one_left) begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    rem_next = rem_reg - 1'b1;
                end
            end
            EMIT_DIGIT: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    char_next  = CHAR_ZERO + {3'd0, top_digit};
                    last_next  = one_left;
                    bcd_next   = {bcd_reg[BCD_W-5:0], 4'd0};
                    rem_next   = rem_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign in_take      = (state_reg == EMIT_IDLE);
    assign m_valid      = valid_reg;
    assign m_ascii_char = char_reg;
    assign m_is_last    = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EMIT_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        bcd_reg  <= bcd_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

>>> hdl/signed_int_to_decimal_ascii.sv
// signed 32-bit integer to decimal ascii text, one character per output beat
// depends on sitda_pkg, sitda_conv, sitda_emit
//
// input channel s_valid/s_ready/s_value: one signed integer per beat
// output channel m_valid/m_ready/m_ascii_char/m_is_last: one character per
// beat, a leading '-' for negative values, then digits most significant
// first with no leading zeros; m_is_last marks the final character
// sequence: the converter shifts one magnitude bit per cycle through the
// shift and add 3 register and then holds its bcd result until the
// emitter takes it; the emitter then presents a minus sign, skips each
// leading zero, moves on to the digits and presents one digit at a time;
// skipped zeros and digits always make ten
// overlap: the next value is accepted the cycle after the handover, so
// conversion of one item overlaps emission of the last
// a stalled receiver holds the output register and backs up into the
// emitter and then the converter; nothing is dropped
// reset (aresetn low, synchronous) empties both stages and the output
module signed_int_to_decimal_ascii (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [sitda_pkg::VALUE_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sitda_pkg::CHAR_W-1:0]       m_ascii_char,
    output logic                               m_is_last
);
    import sitda_pkg::*;

    bcd_beat_t conv_beat;
    logic      emit_take;

    sitda_conv u_conv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_value (s_value),
        .out_beat (conv_beat),
        .out_take (emit_take)
    );

    sitda_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_beat      (conv_beat),
        .in_take      (emit_take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_is_last    (m_is_last)
    );

endmodule

>>> tb/tb_signed_int_to_decimal_ascii.sv
// self-checking testbench for signed_int_to_decimal_ascii: a directed table and
// then random signed values, each output character checked against typed text or a local model
// depends on sitda_pkg and the signed_int_to_decimal_ascii rtl
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
    import sitda_pkg::*;

    localparam int NUM_DIRECTED = 21;
    localparam int NUM_RANDOM   = 440;
    localparam int DRAIN_AT     = 230;
    localparam int TAIL_CYCLES  = 60;
    localparam int MAX_GAP      = 10;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [VALUE_W-1:0]  s_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [CHAR_W-1:0]          m_ascii_char;
    logic                       m_is_last;

    logic [CHAR_W-1:0] exp_chars [$];
    logic              exp_lasts [$];

    int fail_count;
    int values_sent;
    int negatives_sent;
    int full_length_sent;
    int chars_seen;

    logic signed [VALUE_W-1:0] dir_values [NUM_DIRECTED] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sh80000001,
        32'sd9, 32'sd10, -32'sd9, -32'sd10, 32'sd99, 32'sd100,
        32'sd999999999, 32'sd1000000000, -32'sd1000000000, 32'sd1234567890,
        -32'sd1234567890, 32'sh55555555, 32'shaaaaaaaa, 32'sh7ffffffe, 32'sd65536
    };

    // empty text: expected characters come from the model
    string dir_texts [NUM_DIRECTED] = '{
        "0", "1", "-1", "2147483647", "-2147483648", "-2147483647",
        "", "", "", "", "", "",
        "", "", "", "", "", "", "", "", ""
    };

    signed_int_to_decimal_ascii dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_is_last    (m_is_last)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5ms;
        $display("%0t: timeout", $time);
        $display("Some tests failed");
        $finish;
    end

    // decimal text of one value: optional minus, digits msd first, last flagged
    function automatic void queue_decimal_text(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits [NUM_DIGITS];
        int                 nd;
        mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
        nd  = 0;
        if (mag == '0) begin
            digits[0] = 4'd0;
            nd = 1;
        end
        while (mag != '0 && nd < NUM_DIGITS) begin
            digits[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end
        if (v[VALUE_W-1]) begin
            exp_chars.push_back(CHAR_MINUS);
            exp_lasts.push_back(1'b0);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            exp_chars.push_back(CHAR_ZERO + CHAR_W'(digits[i]));
            exp_lasts.push_back(i == 0);
        end
    endfunction

    function automatic void queue_typed_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            exp_chars.push_back(CHAR_W'(text[i]));
            exp_lasts.push_back(i == text.len() - 1);
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_value();
        longint mag;
        longint lo;
        longint hi;
        int     n;
        int     kind;
        bit     neg;
        kind = $urandom_range(9, 0);
        neg  = 1'($urandom_range(1, 0));
        case (kind)
            0, 1, 2, 3: begin
                return $urandom;
            end
            4, 5: begin
                n  = $urandom_range(NUM_DIGITS, 1);
                lo = (n == 1) ? 0 : 10 ** (n - 1);
                hi = (n == NUM_DIGITS) ? 64'd2147483647 : (10 ** n) - 1;
                mag = $urandom_range(int'(hi), int'(lo));
            end
            6: begin
                mag = $urandom_range(99, 0);
            end
            7: begin
                n   = $urandom_range(NUM_DIGITS - 1, 1);
                mag = (10 ** n) + $urandom_range(2, 0) - 1;
            end
            8: begin
                mag = $urandom_range(20, 0);
                return neg ? (32'sh80000000 + VALUE_W'(mag)) : (32'sh7fffffff - VALUE_W'(mag));
            end
            default: begin
                mag = $urandom_range(9, 0);
            end
        endcase
        return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    task automatic send_value(input logic signed [VALUE_W-1:0] v, input string text,
                              input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        if (text.len() > 0)
            queue_typed_text(text);
        else
            queue_decimal_text(v);
        values_sent++;
        if (v[VALUE_W-1])
            negatives_sent++;
        if (v == 32'sh80000000)
            full_length_sent++;
    endtask

    // sender
    initial begin
        bit no_gap;
        int gap;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_value <= '0;
        fail_count = 0;
        values_sent = 0;
        negatives_sent = 0;
        full_length_sent = 0;
        no_gap = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_value(dir_values[i], dir_texts[i], $urandom_range(MAX_GAP, 0));

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 40 == 0)
                no_gap = ($urandom_range(2, 0) == 0);
            if (i == DRAIN_AT) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (exp_chars.size() != 0);
            end
            gap = no_gap ? 0 : $urandom_range(MAX_GAP, 0);
            send_value(random_value(), "", gap);
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (exp_chars.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d values converted (%0d negative, %0d most negative), %0d characters checked",
                 values_sent, negatives_sent, full_length_sent, chars_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: random back-pressure, checks every character beat
    initial begin
        bit                no_stall;
        int                stall;
        logic [CHAR_W-1:0] want_char;
        logic              want_last;
        m_ready <= 1'b0;
        chars_seen = 0;
        no_stall = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (chars_seen % 150 == 0)
                no_stall = ($urandom_range(2, 0) == 0);
            stall = no_stall ? 0 : $urandom_range(MAX_GAP, 0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            chars_seen++;
            if (exp_chars.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual char %0d last %0b",
                         $time, m_ascii_char, m_is_last);
                fail_count++;
            end else begin
                want_char = exp_chars.pop_front();
                want_last = exp_lasts.pop_front();
                if (m_ascii_char !== want_char) begin
                    $display("%0t: ascii_char mismatch, expected %0d actual %0d",
                             $time, want_char, m_ascii_char);
                    fail_count++;
                end
                if (m_is_last !== want_last) begin
                    $display("%0t: is_last mismatch, expected %0b actual %0b",
                             $time, want_last, m_is_last);
                    fail_count++;
                end
            end
        end
    end

endmodule

>>> filelist.f
hdl/sitda_pkg.sv
hdl/sitda_conv.sv
hdl/sitda_emit.sv
hdl/signed_int_to_decimal_ascii.sv
tb/tb_signed_int_to_decimal_ascii.sv
